/* sv/tmqs_pkg.sv */
// ----------------------------------------------------------------------------
// tmqs_pkg
// Shared widths, unit commands and helpers for the mesh quality statistics.
// ----------------------------------------------------------------------------
`default_nettype none

package tmqs_pkg;

  localparam int COORD_W   = 32;
  localparam int DIFF_W    = 33;
  localparam int SIDE_W    = 33;
  localparam int RAD_W     = 34;
  localparam int SQ_W      = 66;
  localparam int DW        = 68;
  localparam int DIV_W     = 35;
  localparam int REM_W     = 38;
  localparam int TRI_W     = 24;
  localparam int CNT_BITS_DEF = 24;
  localparam int IN_W      = 192;
  localparam int OUT_W     = 232;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_SQRT = 2'd1,
    OP_DIV  = 2'd2
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } stat_t;

  function automatic logic [DIFF_W-1:0] mag_of(input logic [DIFF_W-1:0] v);
    mag_of = v[DIFF_W-1] ? (~v + 1'b1) : v;
  endfunction

  // signed quotient from magnitude, saturated to the radius range
  function automatic logic [RAD_W-1:0] sat_rad(input logic neg, input logic [DW-1:0] q);
    logic [RAD_W-1:0] lo;
    lo = q[RAD_W-1:0];
    if (neg) begin
      sat_rad = (q > (DW'(1) << (RAD_W-1))) ? {1'b1, {(RAD_W-1){1'b0}}} : (~lo + 1'b1);
    end else begin
      sat_rad = (q > ((DW'(1) << (RAD_W-1)) - DW'(1))) ? {1'b0, {(RAD_W-1){1'b1}}} : lo;
    end
  endfunction

endpackage

`default_nettype wire

/* sv/tmqs_arith.sv */
// ----------------------------------------------------------------------------
// tmqs_arith
// Shared unit: registered multiply, bit-serial square root (two radicand
// bits a step) and restoring division (one dividend bit a step).
// ----------------------------------------------------------------------------
`default_nettype none

module tmqs_arith (
  input  wire                          clk,
  input  wire                          rst,
  input  tmqs_pkg::cmd_t               cmd,
  input  wire [tmqs_pkg::DW-1:0]       src_in,
  input  wire [tmqs_pkg::DIV_W-1:0]    div_in,
  input  wire [tmqs_pkg::DIFF_W-1:0]   mul_a,
  input  wire [tmqs_pkg::DIFF_W-1:0]   mul_b,
  output tmqs_pkg::stat_t              stat,
  output logic [tmqs_pkg::DW-1:0]      result
);

  localparam int DW    = tmqs_pkg::DW;
  localparam int REM_W = tmqs_pkg::REM_W;

  tmqs_pkg::op_t                 op;
  logic [DW-1:0]                 src;
  logic [DW-1:0]                 acc;
  logic [REM_W-1:0]              rem;
  logic [tmqs_pkg::DIV_W-1:0]    dvs;
  logic [6:0]                    cnt;
  logic                          busy;
  logic                          done;

  logic                          is_sqrt;
  logic [REM_W-1:0]              shifted;
  logic [REM_W-1:0]              rhs;
  logic [REM_W-1:0]              diff;
  logic                          ge;
  logic [tmqs_pkg::SQ_W-1:0]     prod;

  assign is_sqrt = (op == tmqs_pkg::OP_SQRT);
  assign shifted = is_sqrt ? {rem[REM_W-3:0], src[DW-1 -: 2]} : {rem[REM_W-2:0], src[DW-1]};
  assign rhs     = is_sqrt ? {1'b0, acc[34:0], 2'b01} : REM_W'(dvs);
  assign ge      = (shifted >= rhs);
  assign diff    = shifted - rhs;
  assign prod    = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op   <= tmqs_pkg::OP_MUL;
    end else if (busy) begin
      rem  <= ge ? diff : shifted;
      acc  <= {acc[DW-2:0], ge};
      src  <= is_sqrt ? {src[DW-3:0], 2'b00} : {src[DW-2:0], 1'b0};
      cnt  <= cnt - 7'd1;
      done <= (cnt == 7'd1);
      if (cnt == 7'd1) begin
        busy <= 1'b0;
      end
    end else if (cmd.start) begin
      op   <= cmd.op;
      rem  <= '0;
      dvs  <= div_in;
      done <= (cmd.op == tmqs_pkg::OP_MUL);
      case (cmd.op)
        tmqs_pkg::OP_MUL: begin
          acc  <= DW'(prod);
        end
        tmqs_pkg::OP_SQRT: begin
          acc  <= '0;
          src  <= {src_in[DW-3:0], 2'b00};
          cnt  <= 7'd33;
          busy <= 1'b1;
        end
        default: begin
          acc  <= '0;
          src  <= src_in;
          cnt  <= 7'(DW);
          busy <= 1'b1;
        end
      endcase
    end else begin
      done <= 1'b0;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = acc;

endmodule

`default_nettype wire

/* sv/triangle_mesh_quality_stats.sv */
// ----------------------------------------------------------------------------
// triangle_mesh_quality_stats
// Longest side and signed inscribed radius per triangle, with running
// min/max/sum/count, reported and cleared on the last triangle of a mesh.
// ----------------------------------------------------------------------------
// Work per triangle: eight multiplies, three square roots and one divide on
// the shared unit; the last one adds two averaging divides. One triangle is
// taken at a time: s_tready stays low from acceptance until the sequencer is
// back in idle, which on the last triangle waits until the output is free.
// Reset (rst, synchronous) clears the sequencer, output valid and statistics.
`default_nettype none

module triangle_mesh_quality_stats #(
  parameter int COUNT_BITS = tmqs_pkg::CNT_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire [tmqs_pkg::IN_W-1:0]     s_tdata,  // ax, ay, bx, by_coord, cx, cy
  input  wire                          s_tuser,  // item_kind
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [tmqs_pkg::OUT_W-1:0]   m_tdata,  // side_min, side_max, side_avg,
                                                 // radius_min, radius_max,
                                                 // radius_avg, tri_count, pad
  output logic                         m_tuser   // empty_mesh
);

  localparam int D   = tmqs_pkg::DIFF_W;
  localparam int SW  = tmqs_pkg::SIDE_W;
  localparam int RW  = tmqs_pkg::RAD_W;
  localparam int DW  = tmqs_pkg::DW;
  localparam int SSW = SW + COUNT_BITS;
  localparam int RSW = RW + COUNT_BITS;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t state;
  logic [3:0] pc;
  logic       last;

  logic [D-1:0] m_dx10, m_dy10, m_dx20, m_dy20, m_dx21, m_dy21;
  logic         s_dx10, s_dy10, s_dx20, s_dy20;
  logic [tmqs_pkg::SQ_W-1:0] t;
  logic [SW-1:0] sa, sb, sc;
  logic [DW-1:0] det;
  logic [RW-1:0] r;
  logic [SW-1:0] savg;
  logic [RW-1:0] ravg;

  logic [SW-1:0]         side_lo, side_hi;
  logic signed [RW-1:0]  radius_lo, radius_hi;
  logic [SSW-1:0]        side_sum;
  logic signed [RSW-1:0] radius_sum;
  logic [COUNT_BITS-1:0] seen_count;

  tmqs_pkg::cmd_t  cmd;
  tmqs_pkg::stat_t u_stat;
  logic [DW-1:0]   res;
  logic [DW-1:0]   src_in;
  logic [tmqs_pkg::DIV_W-1:0] div_in;
  logic [D-1:0]    mul_a, mul_b;

  logic [tmqs_pkg::DIV_W-1:0] perim;
  logic [DW-1:0]   det_mag;
  logic [RSW-1:0]  rsum_mag;
  logic [SW-1:0]   longest;
  logic [31:0]     cnt32;
  logic [D-1:0]    dx10, dy10, dx20, dy20, dx21, dy21;

  assign dx10 = {s_tdata[95], s_tdata[95:64]}   - {s_tdata[31], s_tdata[31:0]};
  assign dy10 = {s_tdata[127], s_tdata[127:96]} - {s_tdata[63], s_tdata[63:32]};
  assign dx20 = {s_tdata[159], s_tdata[159:128]} - {s_tdata[31], s_tdata[31:0]};
  assign dy20 = {s_tdata[191], s_tdata[191:160]} - {s_tdata[63], s_tdata[63:32]};
  assign dx21 = {s_tdata[159], s_tdata[159:128]} - {s_tdata[95], s_tdata[95:64]};
  assign dy21 = {s_tdata[191], s_tdata[191:160]} - {s_tdata[127], s_tdata[127:96]};

  assign perim    = tmqs_pkg::DIV_W'(sa) + tmqs_pkg::DIV_W'(sb) + tmqs_pkg::DIV_W'(sc);
  assign det_mag  = det[DW-1] ? (~det + 1'b1) : det;
  assign rsum_mag = radius_sum[RSW-1] ? RSW'(-radius_sum) : RSW'(radius_sum);
  assign cnt32    = 32'(seen_count);

  always_comb begin
    longest = sa;
    if (sb > longest) longest = sb;
    if (sc > longest) longest = sc;
  end

  always_comb begin
    mul_a  = m_dx10;
    mul_b  = m_dx10;
    src_in = DW'(t);
    div_in = perim;
    case (pc)
      4'd1:  begin mul_a = m_dy10; mul_b = m_dy10; end
      4'd3:  begin mul_a = m_dx20; mul_b = m_dx20; end
      4'd4:  begin mul_a = m_dy20; mul_b = m_dy20; end
      4'd6:  begin mul_a = m_dx21; mul_b = m_dx21; end
      4'd7:  begin mul_a = m_dy21; mul_b = m_dy21; end
      4'd9:  begin mul_a = m_dx10; mul_b = m_dy20; end
      4'd10: begin mul_a = m_dy10; mul_b = m_dx20; end
      4'd11: src_in = det_mag;
      4'd13: begin src_in = DW'(side_sum); div_in = tmqs_pkg::DIV_W'(seen_count); end
      4'd14: begin src_in = DW'(rsum_mag); div_in = tmqs_pkg::DIV_W'(seen_count); end
      default: ;
    endcase
  end

  always_comb begin
    cmd.start = 1'b0;
    cmd.op    = tmqs_pkg::OP_MUL;
    if (state == ST_ISSUE) begin
      case (pc)
        4'd2, 4'd5, 4'd8: begin cmd.start = 1'b1; cmd.op = tmqs_pkg::OP_SQRT; end
        4'd11: begin cmd.start = (perim != '0); cmd.op = tmqs_pkg::OP_DIV; end
        4'd12, 4'd15: ;
        4'd13: begin cmd.start = (seen_count != '0); cmd.op = tmqs_pkg::OP_DIV; end
        4'd14: begin cmd.start = 1'b1; cmd.op = tmqs_pkg::OP_DIV; end
        default: cmd.start = 1'b1;
      endcase
    end
  end

  tmqs_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .src_in (src_in),
    .div_in (div_in),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .stat   (u_stat),
    .result (res)
  );

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pc         <= '0;
      m_tvalid   <= 1'b0;
      side_lo    <= '1;
      side_hi    <= '0;
      radius_lo  <= {1'b0, {(RW-1){1'b1}}};
      radius_hi  <= {1'b1, {(RW-1){1'b0}}};
      side_sum   <= '0;
      radius_sum <= '0;
      seen_count <= '0;
    end else begin
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            m_dx10 <= tmqs_pkg::mag_of(dx10); s_dx10 <= dx10[D-1];
            m_dy10 <= tmqs_pkg::mag_of(dy10); s_dy10 <= dy10[D-1];
            m_dx20 <= tmqs_pkg::mag_of(dx20); s_dx20 <= dx20[D-1];
            m_dy20 <= tmqs_pkg::mag_of(dy20); s_dy20 <= dy20[D-1];
            m_dx21 <= tmqs_pkg::mag_of(dx21);
            m_dy21 <= tmqs_pkg::mag_of(dy21);
            last   <= s_tuser;
            pc     <= '0;
            state  <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          case (pc)
            4'd11: begin
              if (perim == '0) begin
                r  <= '0;
                pc <= 4'd12;
              end else begin
                state <= ST_WAIT;
              end
            end
            4'd12: begin
              if (longest < side_lo) side_lo <= longest;
              if (longest > side_hi) side_hi <= longest;
              if ($signed(r) < radius_lo) radius_lo <= r;
              if ($signed(r) > radius_hi) radius_hi <= r;
              if (!(&seen_count)) begin
                side_sum   <= side_sum + SSW'(longest);
                radius_sum <= radius_sum + RSW'($signed(r));
                seen_count <= seen_count + 1'b1;
              end
              if (last) pc <= 4'd13;
              else      state <= ST_IDLE;
            end
            4'd13: begin
              if (seen_count == '0) pc <= 4'd15;
              else                  state <= ST_WAIT;
            end
            4'd15: state <= ST_OUT;
            default: state <= ST_WAIT;
          endcase
        end
        ST_WAIT: begin
          if (u_stat.done) begin
            case (pc)
              4'd0, 4'd3, 4'd6: t <= res[tmqs_pkg::SQ_W-1:0];
              4'd1, 4'd4, 4'd7: t <= t + res[tmqs_pkg::SQ_W-1:0];
              4'd2:  sa <= res[SW-1:0];
              4'd5:  sb <= res[SW-1:0];
              4'd8:  sc <= res[SW-1:0];
              4'd9:  det <= (s_dx10 ^ s_dy20) ? (~res + 1'b1) : res;
              4'd10: det <= (s_dy10 ^ s_dx20) ? (det + res) : (det - res);
              4'd11: r <= tmqs_pkg::sat_rad(det[DW-1], res);
              4'd13: savg <= res[SW-1:0];
              4'd14: ravg <= tmqs_pkg::sat_rad(radius_sum[RSW-1], res);
              default: ;
            endcase
            pc    <= pc + 4'd1;
            state <= ST_ISSUE;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            if (seen_count == '0) begin
              m_tdata <= '0;
              m_tuser <= 1'b1;
            end else begin
              m_tdata <= {7'd0,
                          (cnt32 > 32'hFF_FFFF) ? 24'hFF_FFFF : cnt32[23:0],
                          ravg, RW'(radius_hi), RW'(radius_lo),
                          savg, side_hi, side_lo};
              m_tuser <= 1'b0;
            end
            side_lo    <= '1;
            side_hi    <= '0;
            radius_lo  <= {1'b0, {(RW-1){1'b1}}};
            radius_hi  <= {1'b1, {(RW-1){1'b0}}};
            side_sum   <= '0;
            radius_sum <= '0;
            seen_count <= '0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    u_stat.done |-> state == ST_WAIT)
    else $error("unit result outside wait");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("empty mesh with nonzero statistics");

  a_side_order: assert property (@(posedge clk) disable iff (rst)
    seen_count != '0 |-> side_lo <= side_hi)
    else $error("side minimum above maximum");

endmodule

`default_nettype wire
